@@ design/adll_pkg.sv @@
`default_nettype none

package adll_pkg;

   localparam int OPCODE_W = 3;
   localparam int POS_W = 6;
   localparam int VALUE_W = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W = 6;
   localparam int DEFAULT_CAPACITY = 63;

   typedef logic [OPCODE_W-1:0] opcode_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam opcode_type OP_INSERT_AFTER = 3'd0;
   localparam opcode_type OP_INSERT_HEAD = 3'd1;
   localparam opcode_type OP_INSERT_BACK = 3'd2;
   localparam opcode_type OP_DELETE = 3'd3;
   localparam opcode_type OP_POP_HEAD = 3'd4;
   localparam opcode_type OP_POP_BACK = 3'd5;
   localparam opcode_type OP_NEXT = 3'd6;
   localparam opcode_type OP_PREV = 3'd7;

   localparam status_type ST_OK = 2'd0;
   localparam status_type ST_FULL = 2'd1;
   localparam status_type ST_RANGE = 2'd2;
   localparam status_type ST_SENTINEL = 2'd3;

   typedef struct packed {
      status_type                 status;
      logic [POS_W-1:0]           slot_index;
      logic signed [VALUE_W-1:0]  out_value;
      logic [COUNT_W-1:0]         used_count;
   } result_type;

endpackage

`default_nettype wire

@@ design/adll_req_if.sv @@
`default_nettype none

interface adll_req_if import adll_pkg::*;;
   logic                      valid;
   logic                      ready;
   opcode_type                opcode;
   logic [POS_W-1:0]          position;
   logic signed [VALUE_W-1:0] item_value;

   modport source (output valid, opcode, position, item_value, input ready);
   modport sink (input valid, opcode, position, item_value, output ready);
endinterface

`default_nettype wire

@@ design/adll_rsp_if.sv @@
`default_nettype none

interface adll_rsp_if import adll_pkg::*;;
   logic                      valid;
   logic                      ready;
   status_type                status;
   logic [POS_W-1:0]          slot_index;
   logic signed [VALUE_W-1:0] out_value;
   logic [COUNT_W-1:0]        used_count;

   modport source (output valid, status, slot_index, out_value, used_count, input ready);
   modport sink (input valid, status, slot_index, out_value, used_count, output ready);
endinterface

`default_nettype wire

@@ design/adll_ram.sv @@
`default_nettype none

module adll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read at the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/array_doubly_linked_list_core.sv @@
// Doubly linked list of CAPACITY slots with a sentinel at slot 0 and a free
// list threaded through the next links. The next links, prev links and slot
// values sit in three single-port-write, registered-read memories. An insert
// or delete is accepted with the first link read, then makes its link writes
// in S_EXEC1 and S_EXEC2, one write per memory per cycle; next, prev and every
// error finish in S_EXEC1. After reset a clearing pass initialises the link
// memories, during which no request is taken. Results pass through a two-beat
// output buffer, so a new request is taken while the previous result still
// waits on the response channel.
`default_nettype none

module array_doubly_linked_list_core import adll_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input wire logic  clock,
   input wire logic  reset,
   adll_req_if.sink  req,
   adll_rsp_if.source rsp
);

   localparam int DEPTH = CAPACITY + 1;
   localparam int W = $clog2(DEPTH);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE = 2'd1;
   localparam logic [1:0] S_EXEC1 = 2'd2;
   localparam logic [1:0] S_EXEC2 = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [W-1:0]       clr_ff, clr_in;
   logic [W-1:0]       fh_ff, fh_in;
   logic [W-1:0]       count_ff, count_in;
   logic [W-1:0]       head_ff, head_in;
   logic [W-1:0]       tail_ff, tail_in;
   opcode_type         op_ff, op_in;
   logic [W-1:0]       pos_ff, pos_in;
   logic [W-1:0]       slot_ff, slot_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   status_type         st_ff, st_in;
   logic [VALUE_W-1:0] rval_ff, rval_in;

   logic               next_we, prev_we, val_we;
   logic [W-1:0]       next_waddr, prev_waddr, val_waddr;
   logic [W-1:0]       next_wdata, prev_wdata;
   logic [W-1:0]       next_raddr, prev_raddr;
   logic [W-1:0]       next_rd, prev_rd;
   logic [VALUE_W-1:0] val_rd;

   logic               accept;
   logic [W-1:0]       eff_pos;
   logic               pos_range;
   logic               is_ins, is_del;
   logic [W-1:0]       nb_slot;

   logic               res_valid;
   result_type         res;
   logic               out_free;
   logic               rsp_valid_ff, hold_valid_ff;
   result_type         rsp_ff, hold_ff;

   adll_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_waddr),
      .wr_data (next_wdata),
      .rd_addr (next_raddr),
      .rd_data (next_rd)
   );

   adll_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_waddr),
      .wr_data (prev_wdata),
      .rd_addr (prev_raddr),
      .rd_data (prev_rd)
   );

   adll_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_waddr),
      .wr_data (val_ff),
      .rd_addr (prev_raddr),
      .rd_data (val_rd)
   );

   assign req.ready = (state_ff == S_IDLE) && !hold_valid_ff;
   assign accept = req.valid && req.ready;
   assign pos_range = 32'(req.position) > 32'(CAPACITY);

   always_comb begin
      case (req.opcode)
         OP_INSERT_HEAD: eff_pos = '0;
         OP_INSERT_BACK,
         OP_POP_BACK:    eff_pos = tail_ff;
         OP_POP_HEAD:    eff_pos = head_ff;
         default:        eff_pos = W'(req.position);
      endcase
   end

   // Errors are all known at accept time from the request and the registers.
   always_comb begin
      unique case (req.opcode)
         OP_INSERT_AFTER: begin
            if (fh_ff == '0) st_in = ST_FULL;
            else if (pos_range) st_in = ST_RANGE;
            else st_in = ST_OK;
         end
         OP_INSERT_HEAD,
         OP_INSERT_BACK:  st_in = (fh_ff == '0) ? ST_FULL : ST_OK;
         OP_DELETE: begin
            if (req.position == '0) st_in = ST_SENTINEL;
            else if (pos_range) st_in = ST_RANGE;
            else st_in = ST_OK;
         end
         OP_POP_HEAD:     st_in = (head_ff == '0) ? ST_SENTINEL : ST_OK;
         OP_POP_BACK:     st_in = (tail_ff == '0) ? ST_SENTINEL : ST_OK;
         OP_NEXT,
         OP_PREV: begin
            if (pos_range) st_in = ST_RANGE;
            else if (req.position == '0) st_in = ST_SENTINEL;
            else st_in = ST_OK;
         end
         default:         st_in = ST_OK;
      endcase
   end

   assign is_ins = (op_ff == OP_INSERT_AFTER) || (op_ff == OP_INSERT_HEAD)
                   || (op_ff == OP_INSERT_BACK);
   assign is_del = (op_ff == OP_DELETE) || (op_ff == OP_POP_HEAD)
                   || (op_ff == OP_POP_BACK);

   // A neighbour that is the sentinel is skipped by one more link from slot 0.
   always_comb begin
      if (op_ff == OP_NEXT) begin
         nb_slot = (next_rd == '0) ? head_ff : next_rd;
      end else begin
         nb_slot = (prev_rd == '0) ? tail_ff : prev_rd;
      end
   end

   // In the first execute cycle of an insert the next memory is read at the
   // slot being taken, so the old free-list link is read as it is rewritten.
   assign next_raddr = (state_ff == S_IDLE) ? eff_pos : slot_ff;
   assign prev_raddr = (state_ff == S_IDLE) ? eff_pos : pos_ff;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      fh_in = fh_ff;
      count_in = count_ff;
      op_in = op_ff;
      pos_in = pos_ff;
      slot_in = slot_ff;
      val_in = val_ff;
      rval_in = rval_ff;
      next_we = 1'b0;
      next_waddr = pos_ff;
      next_wdata = '0;
      prev_we = 1'b0;
      prev_waddr = pos_ff;
      prev_wdata = '0;
      val_we = 1'b0;
      val_waddr = slot_ff;
      res_valid = 1'b0;
      res.status = st_ff;
      res.slot_index = '0;
      res.out_value = '0;
      res.used_count = COUNT_W'(count_ff);

      unique case (state_ff)
         S_CLEAR: begin
            next_we = 1'b1;
            next_waddr = clr_ff;
            next_wdata = ((clr_ff == '0) || (clr_ff == W'(CAPACITY))) ? '0 : clr_ff + W'(1);
            prev_we = 1'b1;
            prev_waddr = clr_ff;
            prev_wdata = '0;
            clr_in = clr_ff + W'(1);
            if (clr_ff == W'(CAPACITY)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in = req.opcode;
               pos_in = eff_pos;
               val_in = $unsigned(req.item_value);
               if ((req.opcode == OP_INSERT_AFTER) || (req.opcode == OP_INSERT_HEAD)
                   || (req.opcode == OP_INSERT_BACK)) begin
                  slot_in = fh_ff;
               end else begin
                  slot_in = eff_pos;
               end
               state_in = S_EXEC1;
            end
         end
         S_EXEC1: begin
            if ((st_ff != ST_OK) || (!is_ins && !is_del)) begin
               res_valid = 1'b1;
               res.slot_index = (st_ff == ST_OK) ? POS_W'(nb_slot) : '0;
               state_in = S_IDLE;
            end else if (is_ins) begin
               next_we = 1'b1;
               next_waddr = slot_ff;
               next_wdata = next_rd;
               prev_we = 1'b1;
               prev_waddr = next_rd;
               prev_wdata = slot_ff;
               state_in = S_EXEC2;
            end else begin
               next_we = 1'b1;
               next_waddr = prev_rd;
               next_wdata = next_rd;
               prev_we = 1'b1;
               prev_waddr = next_rd;
               prev_wdata = prev_rd;
               rval_in = val_rd;
               state_in = S_EXEC2;
            end
         end
         S_EXEC2: begin
            res_valid = 1'b1;
            state_in = S_IDLE;
            if (is_ins) begin
               fh_in = next_rd;
               prev_we = 1'b1;
               prev_waddr = slot_ff;
               prev_wdata = pos_ff;
               next_we = 1'b1;
               next_waddr = pos_ff;
               next_wdata = slot_ff;
               val_we = 1'b1;
               count_in = (count_ff < W'(CAPACITY)) ? count_ff + W'(1) : count_ff;
               res.slot_index = POS_W'(slot_ff);
            end else begin
               next_we = 1'b1;
               next_waddr = pos_ff;
               next_wdata = fh_ff;
               prev_we = 1'b1;
               prev_waddr = pos_ff;
               prev_wdata = '0;
               fh_in = pos_ff;
               count_in = (count_ff != '0) ? count_ff - W'(1) : count_ff;
               res.slot_index = POS_W'(pos_ff);
               res.out_value = $signed(rval_ff);
            end
            res.used_count = COUNT_W'(count_in);
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Slot 0's links are mirrored in registers so that the head and tail are
   // known in the accept cycle.
   assign head_in = (next_we && (next_waddr == '0)) ? next_wdata : head_ff;
   assign tail_in = (prev_we && (prev_waddr == '0)) ? prev_wdata : tail_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         fh_ff <= W'(1);
         count_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         fh_ff <= fh_in;
         count_ff <= count_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      pos_ff <= pos_in;
      slot_ff <= slot_in;
      val_ff <= val_in;
      rval_ff <= rval_in;
      if (accept) begin
         st_ff <= st_in;
      end
   end

   // Output register with a one-beat hold buffer behind it.
   assign out_free = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         priority if (hold_valid_ff && out_free) begin
            rsp_valid_ff <= 1'b1;
            hold_valid_ff <= 1'b0;
         end else if (res_valid && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (res_valid) begin
            hold_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (hold_valid_ff && out_free) begin
         rsp_ff <= hold_ff;
      end else if (res_valid && out_free) begin
         rsp_ff <= res;
      end
      if (res_valid && !out_free) begin
         hold_ff <= res;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.status = rsp_ff.status;
   assign rsp.slot_index = rsp_ff.slot_index;
   assign rsp.out_value = rsp_ff.out_value;
   assign rsp.used_count = rsp_ff.used_count;

   a_hold_only_idle: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> (state_ff == S_IDLE))
      else $error("hold buffer filled while a request is in flight");

   a_exec2_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC2) |-> ((st_ff == ST_OK) && (is_ins || is_del)))
      else $error("second execute cycle entered by an error or a query");

   a_free_head_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_CLEAR) |-> (32'(fh_ff) <= 32'(CAPACITY)))
      else $error("free head outside the slot range");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(CAPACITY))
      else $error("in-use count above capacity");

   a_no_result_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (!res_valid && !req.ready))
      else $error("request activity during the clearing pass");

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import adll_pkg::*;

   localparam int LIST_CAPACITY = DEFAULT_CAPACITY;
   localparam int STALL_LIMIT = 1000;
   localparam int IDLE_PCT = 22;

   logic clock = 1'b0;
   logic reset = 1'b1;

   adll_req_if req_chan ();
   adll_rsp_if rsp_chan ();

   array_doubly_linked_list_core DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the list held by the block.
   logic [VALUE_W-1:0] list_value [LIST_CAPACITY+1];
   logic [POS_W-1:0]   list_next [LIST_CAPACITY+1];
   logic [POS_W-1:0]   list_prev [LIST_CAPACITY+1];
   logic [POS_W-1:0]   list_free_head;
   int                 list_count;
   bit                 slot_live [LIST_CAPACITY+1];
   bit                 slot_written [LIST_CAPACITY+1];

   result_type pending_results [$];
   bit         mismatch_seen = 1'b0;
   bit         gaps_on = 1'b1;
   int         stall_cycles = 0;

   function automatic void reset_list_model();
      for (int i = 0; i <= LIST_CAPACITY; i++) begin
         list_value[i] = '0;
         list_prev[i] = '0;
         list_next[i] = (i >= 1 && i < LIST_CAPACITY) ? POS_W'(i + 1) : '0;
         slot_live[i] = 1'b0;
         slot_written[i] = 1'b0;
      end
      list_free_head = POS_W'(1);
      list_count = 0;
   endfunction

   function automatic void link_after(logic [POS_W-1:0] anchor, logic [VALUE_W-1:0] value,
                                      output status_type st, output logic [POS_W-1:0] slot);
      logic [POS_W-1:0] fresh;
      slot = '0;
      if (list_free_head == '0) begin
         st = ST_FULL;
      end else if (anchor > LIST_CAPACITY) begin
         st = ST_RANGE;
      end else begin
         // The order of the link updates matters when the anchor is itself
         // the free head, which only happens once the structure is broken.
         fresh = list_free_head;
         list_free_head = list_next[fresh];
         list_prev[list_next[anchor]] = fresh;
         list_next[fresh] = list_next[anchor];
         list_prev[fresh] = anchor;
         list_next[anchor] = fresh;
         list_value[fresh] = value;
         slot_written[fresh] = 1'b1;
         slot_live[fresh] = 1'b1;
         if (list_count < LIST_CAPACITY) list_count++;
         slot = fresh;
         st = ST_OK;
      end
   endfunction

   function automatic void unlink_slot(logic [POS_W-1:0] victim, output status_type st,
                                       output logic [POS_W-1:0] slot,
                                       output logic [VALUE_W-1:0] value);
      logic [POS_W-1:0] p;
      logic [POS_W-1:0] n;
      slot = '0;
      value = '0;
      if (victim == '0) begin
         st = ST_SENTINEL;
      end else if (victim > LIST_CAPACITY) begin
         st = ST_RANGE;
      end else begin
         p = list_prev[victim];
         n = list_next[victim];
         value = list_value[victim];
         list_next[p] = n;
         list_prev[n] = p;
         list_prev[victim] = '0;
         list_next[victim] = list_free_head;
         list_free_head = victim;
         slot_live[victim] = 1'b0;
         if (list_count > 0) list_count--;
         slot = victim;
         st = ST_OK;
      end
   endfunction

   function automatic void find_neighbour(logic [POS_W-1:0] pos, bit forward,
                                          output status_type st,
                                          output logic [POS_W-1:0] slot);
      logic [POS_W-1:0] n;
      slot = '0;
      if (pos > LIST_CAPACITY) begin
         st = ST_RANGE;
      end else if (pos == '0) begin
         st = ST_SENTINEL;
      end else begin
         n = forward ? list_next[pos] : list_prev[pos];
         // Step over the sentinel to wrap round to the other end.
         if (n == '0) n = forward ? list_next[0] : list_prev[0];
         slot = n;
         st = ST_OK;
      end
   endfunction

   function automatic void apply_list_op(opcode_type op, logic [POS_W-1:0] pos,
                                         logic [VALUE_W-1:0] value);
      result_type       res;
      status_type       st;
      logic [POS_W-1:0] slot;
      logic [VALUE_W-1:0] removed;
      removed = '0;
      case (op)
         OP_INSERT_AFTER: link_after(pos, value, st, slot);
         OP_INSERT_HEAD:  link_after('0, value, st, slot);
         OP_INSERT_BACK:  link_after(list_prev[0], value, st, slot);
         OP_DELETE:       unlink_slot(pos, st, slot, removed);
         OP_POP_HEAD:     unlink_slot(list_next[0], st, slot, removed);
         OP_POP_BACK:     unlink_slot(list_prev[0], st, slot, removed);
         OP_NEXT:         find_neighbour(pos, 1'b1, st, slot);
         default:         find_neighbour(pos, 1'b0, st, slot);
      endcase
      if (st != ST_OK) begin
         slot = '0;
         removed = '0;
      end
      res.status = st;
      res.slot_index = slot;
      res.out_value = removed;
      res.used_count = COUNT_W'(list_count);
      pending_results.push_back(res);
   endfunction

   // Returns a random slot that is live (or, with written_only set, written), or 0 if none is.
   function automatic logic [POS_W-1:0] pick_slot(bit written_only);
      logic [POS_W-1:0] pool [$];
      for (int i = 1; i <= LIST_CAPACITY; i++) begin
         if (written_only ? slot_written[i] : slot_live[i]) pool.push_back(POS_W'(i));
      end
      if (pool.size() == 0) return '0;
      return pool[$urandom_range(pool.size() - 1)];
   endfunction

   task automatic send_request(opcode_type op, logic [POS_W-1:0] pos,
                               logic [VALUE_W-1:0] value);
      while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.opcode <= op;
      req_chan.position <= pos;
      req_chan.item_value <= value;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      apply_list_op(op, pos, value);
   endtask

   task automatic test_edge_cases();
      // Everything on an empty list first, then a short list of four.
      send_request(OP_POP_HEAD, '0, '0);
      send_request(OP_POP_BACK, '0, '0);
      send_request(OP_NEXT, '0, '0);
      send_request(OP_PREV, '0, '0);
      send_request(OP_DELETE, '0, '0);
      send_request(OP_NEXT, POS_W'(5), '0);
      send_request(OP_PREV, POS_W'(LIST_CAPACITY), '0);
      send_request(OP_INSERT_HEAD, '1, 32'h7fff_ffff);
      send_request(OP_INSERT_BACK, '0, 32'h8000_0000);
      send_request(OP_INSERT_AFTER, '0, 32'hffff_ffff);
      send_request(OP_INSERT_AFTER, POS_W'(1), 32'h0000_0000);
      send_request(OP_NEXT, POS_W'(2), '0);
      send_request(OP_PREV, POS_W'(3), '0);
      send_request(OP_NEXT, POS_W'(3), '0);
      send_request(OP_PREV, POS_W'(4), '0);
      send_request(OP_DELETE, POS_W'(1), '0);
      send_request(OP_POP_HEAD, '0, '1);
      send_request(OP_POP_BACK, '0, '0);
      send_request(OP_POP_HEAD, '0, '0);
      send_request(OP_POP_BACK, '0, '0);
   endtask

   task automatic test_fill_and_drain();
      int kind;
      while (list_free_head != '0) begin
         kind = $urandom_range(2);
         if (kind == 0) send_request(OP_INSERT_AFTER, pick_slot(1'b0), $urandom());
         else if (kind == 1) send_request(OP_INSERT_HEAD, '0, $urandom());
         else send_request(OP_INSERT_BACK, '0, $urandom());
      end
      send_request(OP_INSERT_BACK, '0, $urandom());
      send_request(OP_INSERT_AFTER, POS_W'(LIST_CAPACITY), $urandom());
      send_request(OP_NEXT, POS_W'(LIST_CAPACITY), '0);
      send_request(OP_PREV, POS_W'(1), '0);
      send_request(OP_NEXT, list_prev[0], '0);
      send_request(OP_PREV, list_next[0], '0);
      send_request(OP_DELETE, POS_W'(LIST_CAPACITY), '0);
      while (list_count > 0) begin
         kind = $urandom_range(2);
         if (kind == 0) send_request(OP_DELETE, pick_slot(1'b0), '0);
         else if (kind == 1) send_request(OP_POP_HEAD, '0, '0);
         else send_request(OP_POP_BACK, '0, '0);
      end
      send_request(OP_POP_BACK, '0, '0);
   endtask

   task automatic test_random_traffic();
      int insert_pct;
      int roll;
      logic [POS_W-1:0] pos;
      insert_pct = 50;
      for (int k = 0; k < 440; k++) begin
         // The fill level drifts up and down as the insert share changes.
         if (k % 60 == 0) insert_pct = 25 + 25 * $urandom_range(2);
         gaps_on = !(k >= 180 && k < 300);
         roll = $urandom_range(99);
         pos = pick_slot(1'b0);
         if (roll < 2) begin
            send_request(OP_DELETE, '0, $urandom());
         end else if (roll < 4) begin
            send_request(roll == 2 ? OP_NEXT : OP_PREV, '0, $urandom());
         end else if (roll < 24) begin
            send_request(roll < 14 ? OP_NEXT : OP_PREV, pos, $urandom());
         end else if ($urandom_range(99) < insert_pct) begin
            case ($urandom_range(2))
               0: begin
                  if ($urandom_range(7) == 0) pos = '0;
                  send_request(OP_INSERT_AFTER, pos, $urandom());
               end
               1: send_request(OP_INSERT_HEAD, POS_W'($urandom()), $urandom());
               default: send_request(OP_INSERT_BACK, POS_W'($urandom()), $urandom());
            endcase
         end else begin
            case ($urandom_range(2))
               0: send_request(OP_DELETE, pos, $urandom());
               1: send_request(OP_POP_HEAD, POS_W'($urandom()), $urandom());
               default: send_request(OP_POP_BACK, POS_W'($urandom()), $urandom());
            endcase
         end
      end
      gaps_on = 1'b1;
   endtask

   task automatic test_broken_structure();
      opcode_type op;
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] victim;
      for (int k = 0; k < 80; k++) begin
         op = opcode_type'($urandom_range(7));
         pos = POS_W'($urandom_range(LIST_CAPACITY));
         // Slots without a stored value are never removed.
         if (op == OP_DELETE && pos != '0 && !slot_written[pos]) pos = pick_slot(1'b1);
         if (op == OP_POP_HEAD || op == OP_POP_BACK) begin
            victim = (op == OP_POP_HEAD) ? list_next[0] : list_prev[0];
            if (victim != '0 && !slot_written[victim]) op = OP_NEXT;
         end
         send_request(op, pos, $urandom());
      end
   endtask

   task automatic check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatch_seen = 1'b1;
      end
   endtask

   always @(posedge clock) begin : check_results
      result_type want;
      if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $error("result beat with nothing outstanding: status %0d slot %0d",
                   rsp_chan.status, rsp_chan.slot_index);
            mismatch_seen = 1'b1;
         end else begin
            want = pending_results.pop_front();
            check_field("status", VALUE_W'(want.status), VALUE_W'(rsp_chan.status));
            check_field("slot_index", VALUE_W'(want.slot_index),
                        VALUE_W'(rsp_chan.slot_index));
            check_field("out_value", want.out_value, rsp_chan.out_value);
            check_field("used_count", VALUE_W'(want.used_count),
                        VALUE_W'(rsp_chan.used_count));
         end
      end
   end

   always @(posedge clock) begin
      rsp_chan.ready <= gaps_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
   end

   always @(posedge clock) begin
      if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("array_doubly_linked_list_core: mismatch");
         $finish;
      end
   end

   initial begin
      req_chan.valid <= 1'b0;
      req_chan.opcode <= OP_INSERT_AFTER;
      req_chan.position <= '0;
      req_chan.item_value <= '0;
      reset_list_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_edge_cases();
      test_fill_and_drain();
      test_random_traffic();
      test_broken_structure();
      req_chan.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (!mismatch_seen) begin
         $display("array_doubly_linked_list_core: match");
      end else begin
         $display("array_doubly_linked_list_core: mismatch");
      end
      $finish;
   end

endmodule
